>>> hdl/upd_pkg.sv
// upd_pkg: shared types, constants and helpers for the url percent decoder
// used by upd_front, upd_queue, upd_back and url_percent_decoder; no dependencies
package upd_pkg;

  // decoded-result queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // characters of interest
  localparam logic [7:0] CH_PCT     = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_U = 8'h75;
  localparam logic [7:0] CH_UPPER_U = 8'h55;

  // utf-8 framing
  localparam logic [7:0]  UTF_LEAD2  = 8'd192;
  localparam logic [7:0]  UTF_LEAD3  = 8'd224;
  localparam logic [7:0]  UTF_CONT   = 8'd128;
  localparam logic [15:0] UTF_LIM1   = 16'h0080;
  localparam logic [15:0] UTF_LIM2   = 16'h0800;
  localparam logic [4:0]  SURR_TOP   = 5'b11011;

  // one group of results caused by one input beat
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      n;
    logic            data;
    logic            err;
    logic            eos;
  } pkt_t;

  // {ok, value} of a hex digit in either case
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage

>>> hdl/url_percent_decoder.sv
// url_percent_decoder: percent / %u0xxxx url decoder with utf-8 output
// a taken beat's result group is registered in the queue, read out from its head
// throughput: one beat per cycle unless full; an escape giving two or three bytes
// holds the result side for that many pop beats, absorbed by a four-group queue
// reset (synchronous, rst_n low) clears parser state, error flag and queue
// depends on upd_pkg, upd_front, upd_queue, upd_back
module url_percent_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_has_data,
  output logic       out_decode_error,
  output logic       out_end_of_string
);

  upd_pkg::pkt_t pkt, head;
  logic          pkt_push;
  logic          q_full, q_empty, q_pop;
  logic          accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  upd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .pkt_push (pkt_push),
    .pkt      (pkt)
  );

  upd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (pkt_push),
    .wr_pkt  (pkt),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .head    (head)
  );

  upd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_has_data      (out_has_data),
    .out_decode_error  (out_decode_error),
    .out_end_of_string (out_end_of_string)
  );

endmodule

>>> hdl/upd_front.sv
// upd_front: escape parser; turns each accepted input beat into a result group
// depends on upd_pkg
module upd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          pkt_push,
  output upd_pkg::pkt_t pkt
);

  typedef enum logic [2:0] {PH_IDLE, PH_PCT, PH_HEX2, PH_UZERO, PH_UHEX} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  digits_r, digits_nxt;
  logic [15:0] value_r, value_nxt;
  logic        err_seen_r;

  logic [4:0]  hx;
  logic [15:0] uval;
  logic        bad;
  logic [1:0]  cnt;
  logic [7:0]  b0, b1, b2;

  assign hx   = upd_pkg::hex_digit(in_byte);
  assign uval = {value_r[11:0], hx[3:0]};

  always_comb begin
    phase_nxt  = phase_r;
    digits_nxt = digits_r;
    value_nxt  = value_r;
    bad        = 1'b0;
    cnt        = 2'd0;
    b0         = 8'h00;
    b1         = 8'h00;
    b2         = 8'h00;
    case (phase_r)
      PH_PCT: begin
        if (in_byte == upd_pkg::CH_LOWER_U || in_byte == upd_pkg::CH_UPPER_U) begin
          phase_nxt = PH_UZERO;
        end else if (!hx[4]) begin
          bad = 1'b1;
        end else begin
          value_nxt = {12'h000, hx[3:0]};
          phase_nxt = PH_HEX2;
        end
      end
      PH_HEX2: begin
        if (!hx[4]) begin
          bad = 1'b1;
        end else begin
          b0        = {value_r[3:0], hx[3:0]};
          cnt       = 2'd1;
          phase_nxt = PH_IDLE;
          value_nxt = 16'h0000;
        end
      end
      PH_UZERO: begin
        if (in_byte == upd_pkg::CH_ZERO) begin
          phase_nxt  = PH_UHEX;
          digits_nxt = 2'd0;
          value_nxt  = 16'h0000;
        end else begin
          bad = 1'b1;
        end
      end
      PH_UHEX: begin
        if (!hx[4]) begin
          bad = 1'b1;
        end else if (digits_r == 2'd3) begin
          // fourth digit: emit utf-8
          if (uval < upd_pkg::UTF_LIM1) begin
            b0  = uval[7:0];
            cnt = 2'd1;
          end else if (uval < upd_pkg::UTF_LIM2) begin
            b0  = upd_pkg::UTF_LEAD2 + {3'b000, uval[10:6]};
            b1  = upd_pkg::UTF_CONT + {2'b00, uval[5:0]};
            cnt = 2'd2;
          end else if (uval[15:11] == upd_pkg::SURR_TOP) begin
            cnt = 2'd0;
          end else begin
            b0  = upd_pkg::UTF_LEAD3 + {4'h0, uval[15:12]};
            b1  = upd_pkg::UTF_CONT + {2'b00, uval[11:6]};
            b2  = upd_pkg::UTF_CONT + {2'b00, uval[5:0]};
            cnt = 2'd3;
          end
          phase_nxt  = PH_IDLE;
          digits_nxt = 2'd0;
          value_nxt  = 16'h0000;
        end else begin
          value_nxt  = uval;
          digits_nxt = digits_r + 2'd1;
        end
      end
      default: begin
        if (in_byte == upd_pkg::CH_PLUS) begin
          b0  = upd_pkg::CH_SPACE;
          cnt = 2'd1;
        end else if (in_byte == upd_pkg::CH_PCT) begin
          phase_nxt = PH_PCT;
        end else begin
          b0  = in_byte;
          cnt = 2'd1;
        end
      end
    endcase
  end

  // result group for this beat
  always_comb begin
    pkt       = '0;
    pkt.n     = 2'd1;
    pkt_push  = 1'b0;
    if (err_seen_r) begin
      pkt.err  = 1'b1;
      pkt.eos  = 1'b1;
      pkt_push = accept && in_last;
    end else if (bad) begin
      pkt.err  = 1'b1;
      pkt.eos  = in_last;
      pkt_push = accept;
    end else if (in_last && phase_nxt != PH_IDLE) begin
      // string ended inside an escape
      pkt.err  = 1'b1;
      pkt.eos  = 1'b1;
      pkt_push = accept;
    end else if (cnt != 2'd0) begin
      pkt.bytes = {b2, b1, b0};
      pkt.n     = cnt;
      pkt.data  = 1'b1;
      pkt.eos   = in_last;
      pkt_push  = accept;
    end else begin
      pkt.eos  = 1'b1;
      pkt_push = accept && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      digits_r   <= 2'd0;
      value_r    <= 16'h0000;
      err_seen_r <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        phase_r    <= PH_IDLE;
        digits_r   <= 2'd0;
        value_r    <= 16'h0000;
        err_seen_r <= 1'b0;
      end else if (err_seen_r) begin
        err_seen_r <= 1'b1;
      end else if (bad) begin
        // swallow the rest of the string
        phase_r    <= PH_IDLE;
        digits_r   <= 2'd0;
        value_r    <= 16'h0000;
        err_seen_r <= 1'b1;
      end else begin
        phase_r  <= phase_nxt;
        digits_r <= digits_nxt;
        value_r  <= value_nxt;
      end
    end
  end

  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    err_seen_r |-> phase_r == PH_IDLE)
    else $error("error flag set inside an escape");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |=> phase_r == PH_IDLE && !err_seen_r && digits_r == 2'd0)
    else $error("parser state not cleared after final beat");

endmodule

>>> hdl/upd_queue.sv
// upd_queue: short queue of result groups between parser and output stage
// depends on upd_pkg
module upd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  upd_pkg::pkt_t wr_pkt,
  output logic          q_full,
  input  logic          q_pop,
  output logic          q_empty,
  output upd_pkg::pkt_t head
);

  upd_pkg::pkt_t               mem [upd_pkg::QDEPTH];
  logic [upd_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [upd_pkg::QCNT_W-1:0] count_r;

  assign q_full  = count_r == upd_pkg::QCNT_W'(upd_pkg::QDEPTH);
  assign q_empty = count_r == '0;
  assign head    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !q_pop) count_r <= count_r + 1'b1;
      else if (!push && q_pop) count_r <= count_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty))
    else $error("pop from empty queue");

endmodule

>>> hdl/upd_back.sv
// upd_back: walks the head result group one beat at a time onto the result ports
// depends on upd_pkg
module upd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  upd_pkg::pkt_t head,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte,
  output logic          out_has_data,
  output logic          out_decode_error,
  output logic          out_end_of_string
);

  logic [1:0] idx_r;
  logic       take;
  logic       final_one;

  assign empty     = q_empty;
  assign take      = pop && !q_empty;
  assign final_one = 2'(idx_r + 2'd1) == head.n;
  assign q_pop     = take && final_one;

  assign out_byte          = head.data ? head.bytes[idx_r] : 8'h00;
  assign out_has_data      = head.data;
  assign out_decode_error  = head.err;
  assign out_end_of_string = head.eos && final_one;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (take) begin
      idx_r <= final_one ? 2'd0 : idx_r + 2'd1;
    end
  end

  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> idx_r < head.n)
    else $error("result index past end of group");

endmodule

>>> dv/url_percent_decoder_tb.sv
// url_percent_decoder_tb: self-checking bench for the url percent decoder, directed rows
// then random strings, every popped beat checked against a typed row or in-bench decoder
// depends on upd_pkg and url_percent_decoder
module url_percent_decoder_tb;

  localparam int N_RANDOM    = 457;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_AT    = 300;

  typedef enum logic [2:0] {ESC_NONE, ESC_PCT, ESC_HEX2, ESC_UZERO, ESC_UHEX} esc_phase_t;

  typedef struct packed {
    logic [7:0] b;
    logic       hd;
    logic       err;
    logic       eos;
  } dec_res_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    dec_res_t   want;
  } text_beat_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       in_last;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic       out_has_data;
  logic       out_decode_error;
  logic       out_end_of_string;

  url_percent_decoder DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_byte           (in_byte),
    .in_last           (in_last),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_has_data      (out_has_data),
    .out_decode_error  (out_decode_error),
    .out_end_of_string (out_end_of_string)
  );

  always #2 clk = ~clk;

  // decoder state kept by the bench
  esc_phase_t  esc_phase;
  logic [2:0]  esc_digits;
  logic [15:0] esc_val;
  logic        str_bad;

  dec_res_t   beat_res [$];
  dec_res_t   pending_results [$];
  text_beat_t stim_q [$];
  text_beat_t directed_tab [23];
  text_beat_t cur_row;
  dec_res_t   seen_res;
  dec_res_t   want_res;

  int mismatches   = 0;
  int beats_in     = 0;
  int strings_in   = 0;
  int results_out  = 0;
  int bad_strings  = 0;
  int empty_closes = 0;
  int full_stalls  = 0;
  int stall_cycles = 0;

  function automatic dec_res_t mk_res(logic [7:0] b, logic hd, logic err, logic eos);
    return {b, hd, err, eos};
  endfunction

  function automatic text_beat_t row(logic [7:0] b, logic last);
    return {b, last, 1'b0, 11'b0};
  endfunction

  function automatic text_beat_t rowx(logic [7:0] b, logic last, logic [7:0] ob,
                                      logic hd, logic err, logic eos);
    return {b, last, 1'b1, ob, hd, err, eos};
  endfunction

  // {valid, value} of an ascii hex digit
  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'b0;
  endfunction

  task automatic clear_parse();
    esc_phase  = ESC_NONE;
    esc_digits = 3'd0;
    esc_val    = 16'h0000;
    str_bad    = 1'b0;
  endtask

  // fills beat_res with what one input beat must produce
  task automatic decode_beat(input logic [7:0] c, input logic last);
    logic [4:0]  nib;
    logic [7:0]  bytes_q [$];
    logic        bad;
    logic [15:0] v;
    beat_res.delete();
    bad = 1'b0;
    nib = nibble_of(c);
    if (str_bad) begin
      if (last) begin
        beat_res.insert(beat_res.size(), mk_res(8'h00, 1'b0, 1'b1, 1'b1));
        clear_parse();
      end
    end else begin
      case (esc_phase)
        ESC_PCT: begin
          if (c == upd_pkg::CH_LOWER_U || c == upd_pkg::CH_UPPER_U) esc_phase = ESC_UZERO;
          else if (!nib[4]) bad = 1'b1;
          else begin
            esc_val   = {12'h000, nib[3:0]};
            esc_phase = ESC_HEX2;
          end
        end
        ESC_HEX2: begin
          if (!nib[4]) bad = 1'b1;
          else begin
            bytes_q.insert(bytes_q.size(), {esc_val[3:0], nib[3:0]});
            esc_phase = ESC_NONE;
            esc_val   = 16'h0000;
          end
        end
        ESC_UZERO: begin
          if (c == upd_pkg::CH_ZERO) begin
            esc_phase  = ESC_UHEX;
            esc_digits = 3'd0;
            esc_val    = 16'h0000;
          end else begin
            bad = 1'b1;
          end
        end
        ESC_UHEX: begin
          if (!nib[4]) bad = 1'b1;
          else begin
            esc_val    = {esc_val[11:0], nib[3:0]};
            esc_digits = esc_digits + 3'd1;
            if (esc_digits >= 3'd4) begin
              v = esc_val;
              if (v < upd_pkg::UTF_LIM1) begin
                bytes_q.insert(bytes_q.size(), v[7:0]);
              end else if (v < upd_pkg::UTF_LIM2) begin
                bytes_q.insert(bytes_q.size(), upd_pkg::UTF_LEAD2 | {3'b000, v[10:6]});
                bytes_q.insert(bytes_q.size(), upd_pkg::UTF_CONT | {2'b00, v[5:0]});
              end else if (v[15:11] != upd_pkg::SURR_TOP) begin
                bytes_q.insert(bytes_q.size(), upd_pkg::UTF_LEAD3 | {4'h0, v[15:12]});
                bytes_q.insert(bytes_q.size(), upd_pkg::UTF_CONT | {2'b00, v[11:6]});
                bytes_q.insert(bytes_q.size(), upd_pkg::UTF_CONT | {2'b00, v[5:0]});
              end
              esc_phase  = ESC_NONE;
              esc_digits = 3'd0;
              esc_val    = 16'h0000;
            end
          end
        end
        default: begin
          if (c == upd_pkg::CH_PLUS) bytes_q.insert(bytes_q.size(), upd_pkg::CH_SPACE);
          else if (c == upd_pkg::CH_PCT) esc_phase = ESC_PCT;
          else bytes_q.insert(bytes_q.size(), c);
        end
      endcase

      if (bad) begin
        beat_res.insert(beat_res.size(), mk_res(8'h00, 1'b0, 1'b1, last));
        clear_parse();
        // rest of the string is swallowed up to its last byte
        if (!last) str_bad = 1'b1;
      end else if (last && esc_phase != ESC_NONE) begin
        beat_res.insert(beat_res.size(), mk_res(8'h00, 1'b0, 1'b1, 1'b1));
        clear_parse();
      end else begin
        foreach (bytes_q[i])
          beat_res.insert(beat_res.size(),
                          mk_res(bytes_q[i], 1'b1, 1'b0, last && i == bytes_q.size() - 1));
        if (last) begin
          if (bytes_q.size() == 0)
            beat_res.insert(beat_res.size(), mk_res(8'h00, 1'b0, 1'b0, 1'b1));
          clear_parse();
        end
      end
    end
  endtask

  task automatic report_mismatch(input string why, input dec_res_t want, input dec_res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"mismatch (%s): want byte %h data %b err %b eos %b, ",
                "got byte %h data %b err %b eos %b"},
               why, want.b, want.hd, want.err, want.eos, got.b, got.hd, got.err, got.eos);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    logic [7:0] base;
    if (n < 4'd10) return upd_pkg::CH_ZERO + {4'h0, n};
    base = ($urandom_range(0, 1) != 0) ? "a" : "A";
    return base + {4'h0, n - 4'd10};
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == upd_pkg::CH_PCT);
    return c;
  endfunction

  // anything that can not continue an escape
  function automatic logic [7:0] bad_digit();
    logic [7:0] c;
    logic [4:0] nib;
    do begin
      c   = 8'($urandom_range(0, 255));
      nib = nibble_of(c);
    end while (nib[4] || c == upd_pkg::CH_LOWER_U || c == upd_pkg::CH_UPPER_U);
    return c;
  endfunction

  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 9))
          0: return 16'h0000;
          1: return 16'h007f;
          2: return 16'h0080;
          3: return 16'h07ff;
          4: return 16'h0800;
          5: return 16'hd7ff;
          6: return 16'hd800;
          7: return 16'hdfff;
          8: return 16'he000;
          default: return 16'hffff;
        endcase
      end
      1: return 16'($urandom_range(16'h0000, 16'h007f));
      2: return 16'($urandom_range(16'h0080, 16'h07ff));
      3, 4: return 16'($urandom_range(16'h0800, 16'hd7ff));
      5: return 16'($urandom_range(16'hd800, 16'hdfff));
      6, 7: return 16'($urandom_range(16'he000, 16'hffff));
      default: return 16'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  // one string: mostly well-formed escapes with random content, some broken, some raw noise
  task automatic gen_string();
    logic [7:0]  txt [$];
    logic [15:0] v;
    int          kind;
    int          k;
    int          j;
    int          p;
    bit          cut;
    cut = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
    end else begin
      for (k = $urandom_range(1, 10); k > 0 && !cut; k--) begin
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
          txt.insert(txt.size(), plain_byte());
        end else if (kind < 38) begin
          txt.insert(txt.size(), upd_pkg::CH_PLUS);
        end else if (kind < 58) begin
          txt.insert(txt.size(), upd_pkg::CH_PCT);
          txt.insert(txt.size(), hex_char(4'($urandom_range(0, 15))));
          txt.insert(txt.size(), hex_char(4'($urandom_range(0, 15))));
        end else if (kind < 86) begin
          v = pick_code();
          txt.insert(txt.size(), upd_pkg::CH_PCT);
          txt.insert(txt.size(), ($urandom_range(0, 1) != 0) ? upd_pkg::CH_LOWER_U
                                                             : upd_pkg::CH_UPPER_U);
          txt.insert(txt.size(), upd_pkg::CH_ZERO);
          for (j = 0; j < 4; j++) txt.insert(txt.size(), hex_char(v[4 * (3 - j) +: 4]));
        end else begin
          p = $urandom_range(0, 4);
          txt.insert(txt.size(), upd_pkg::CH_PCT);
          case (p)
            0: txt.insert(txt.size(), bad_digit());
            1: begin
              txt.insert(txt.size(), hex_char(4'($urandom_range(0, 15))));
              txt.insert(txt.size(), bad_digit());
            end
            2: begin
              txt.insert(txt.size(), upd_pkg::CH_LOWER_U);
              do v[7:0] = 8'($urandom_range(0, 255)); while (v[7:0] == upd_pkg::CH_ZERO);
              txt.insert(txt.size(), v[7:0]);
            end
            3: begin
              txt.insert(txt.size(), upd_pkg::CH_UPPER_U);
              txt.insert(txt.size(), upd_pkg::CH_ZERO);
              repeat ($urandom_range(0, 3))
                txt.insert(txt.size(), hex_char(4'($urandom_range(0, 15))));
              txt.insert(txt.size(), bad_digit());
            end
            default: begin
              // string stops part way into an escape
              p = $urandom_range(0, 5);
              if (p == 1) txt.insert(txt.size(), hex_char(4'($urandom_range(0, 15))));
              if (p >= 2) txt.insert(txt.size(), upd_pkg::CH_LOWER_U);
              if (p >= 3) txt.insert(txt.size(), upd_pkg::CH_ZERO);
              if (p >= 4)
                repeat ((p == 4) ? 1 : $urandom_range(2, 3))
                  txt.insert(txt.size(), hex_char(4'($urandom_range(0, 15))));
              cut = 1'b1;
            end
          endcase
        end
      end
    end
    foreach (txt[i]) stim_q.insert(stim_q.size(), row(txt[i], i == txt.size() - 1));
  endtask

  // check popped beats, predict taken beats, watchdog
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      results_out++;
      seen_res = {out_byte, out_has_data, out_decode_error, out_end_of_string};
      if (seen_res.eos && seen_res.err) bad_strings++;
      if (seen_res.eos && !seen_res.err && !seen_res.hd) empty_closes++;
      if (pending_results.size() == 0) begin
        report_mismatch("nothing owed", 11'b0, seen_res);
      end else begin
        want_res = pending_results.pop_front();
        if (seen_res.b !== want_res.b || seen_res.hd !== want_res.hd ||
            seen_res.err !== want_res.err || seen_res.eos !== want_res.eos)
          report_mismatch("field", want_res, seen_res);
      end
    end
    if (rst_n && push) begin
      if (full) begin
        full_stalls++;
      end else begin
        beats_in++;
        if (in_last) strings_in++;
        decode_beat(in_byte, in_last);
        if (cur_row.typed) pending_results.insert(pending_results.size(), cur_row.want);
        else foreach (beat_res[k]) pending_results.insert(pending_results.size(), beat_res[k]);
      end
    end
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles, %0d results still owed",
                 stall_cycles, pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result side: random pop gaps, one long hold-off to back the queue up
  initial begin : rx_side
    int  idle;
    int  calm;
    bit  held;
    pop  = 1'b0;
    idle = 0;
    calm = 0;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held && beats_in >= 200) begin
        held = 1'b1;
        pop  = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (idle > 0) begin
        pop = 1'b0;
        idle--;
      end else begin
        pop = 1'b1;
        if (calm > 0) calm--;
        else begin
          idle = pick_gap();
          if ($urandom_range(0, 40) == 0) calm = $urandom_range(30, 80);
        end
      end
    end
  end

  initial begin : tx_side
    int gap;
    int calm;
    int n_dir;
    rst_n   = 1'b0;
    push    = 1'b0;
    in_byte = 8'h00;
    in_last = 1'b0;
    cur_row = '0;
    calm    = 0;
    clear_parse();

    // typed rows: plain bytes, '+', surrogate close, bad digit, swallowed tail,
    // missing zero after %u, string ending inside an escape
    directed_tab = '{
      rowx("A",                 1'b0, "A",               1'b1, 1'b0, 1'b0),
      rowx(8'hff,               1'b0, 8'hff,             1'b1, 1'b0, 1'b0),
      rowx(8'h00,               1'b0, 8'h00,             1'b1, 1'b0, 1'b0),
      rowx(upd_pkg::CH_PLUS,    1'b1, upd_pkg::CH_SPACE, 1'b1, 1'b0, 1'b1),
      row(upd_pkg::CH_PCT,      1'b0),
      row("a",                  1'b0),
      row("F",                  1'b1),
      row(upd_pkg::CH_PCT,      1'b0),
      row(upd_pkg::CH_UPPER_U,  1'b0),
      row(upd_pkg::CH_ZERO,     1'b0),
      row("d",                  1'b0),
      row("F",                  1'b0),
      row("F",                  1'b0),
      rowx("F",                 1'b1, 8'h00,             1'b0, 1'b0, 1'b1),
      row(upd_pkg::CH_PCT,      1'b0),
      rowx("g",                 1'b0, 8'h00,             1'b0, 1'b1, 1'b0),
      row(upd_pkg::CH_PCT,      1'b0),
      rowx("Z",                 1'b1, 8'h00,             1'b0, 1'b1, 1'b1),
      row(upd_pkg::CH_PCT,      1'b0),
      row(upd_pkg::CH_LOWER_U,  1'b0),
      rowx("x",                 1'b1, 8'h00,             1'b0, 1'b1, 1'b1),
      rowx("B",                 1'b0, "B",               1'b1, 1'b0, 1'b0),
      rowx(upd_pkg::CH_PCT,     1'b1, 8'h00,             1'b0, 1'b1, 1'b1)
    };
    foreach (directed_tab[i]) stim_q.insert(stim_q.size(), directed_tab[i]);
    n_dir = stim_q.size();
    while (stim_q.size() < n_dir + N_RANDOM) gen_string();

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < stim_q.size(); i++) begin
      // sender waits for the block to drain completely
      if (i == n_dir || i == DRAIN_AT) begin
        push = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      if (calm > 0) begin
        calm--;
        gap = 0;
      end else begin
        gap = pick_gap();
        if ($urandom_range(0, 40) == 0) calm = $urandom_range(30, 80);
      end
      if (gap > 0) begin
        push = 1'b0;
        repeat (gap) @(negedge clk);
      end
      cur_row = stim_q[i];
      in_byte = cur_row.b;
      in_last = cur_row.last;
      push    = 1'b1;
      @(posedge clk);
      while (full) @(posedge clk);
      @(negedge clk);
    end
    push = 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("run: %0d encoded beats in %0d strings gave %0d decoded beats",
             beats_in, strings_in, results_out);
    $display("run: %0d malformed strings, %0d empty closes, %0d cycles of input back-pressure",
             bad_strings, empty_closes, full_stalls);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
